@@ sv/v4n_pkg.sv @@
// ---------------------------------------------------------------------------
// v4n_pkg: shared types and constants for the vector normalizer
// Payload structs for the input and result items, and the default width.
// ---------------------------------------------------------------------------
`default_nettype none
package v4n_pkg;
  localparam int DEF_COMP_WIDTH = 16;
  localparam int UNIT_W = 16;
  localparam int LEN_W = 17;
  localparam int Q_SHIFT = 14;

  typedef struct packed {
    logic signed [DEF_COMP_WIDTH-1:0] comp_x;
    logic signed [DEF_COMP_WIDTH-1:0] comp_y;
    logic signed [DEF_COMP_WIDTH-1:0] comp_z;
    logic signed [DEF_COMP_WIDTH-1:0] comp_w;
  } vec_in_t;

  typedef struct packed {
    logic signed [UNIT_W-1:0] unit_x;
    logic signed [UNIT_W-1:0] unit_y;
    logic signed [UNIT_W-1:0] unit_z;
    logic signed [UNIT_W-1:0] unit_w;
    logic [LEN_W-1:0]         length;
    logic                     zero_error;
  } vec_out_t;
endpackage
`default_nettype wire

@@ sv/v4n_sqrt_cell.sv @@
// ---------------------------------------------------------------------------
// v4n_sqrt_cell: one stage of the digit-by-digit square root chain
// Resolves one result bit per cycle and forwards the magnitudes alongside.
// ---------------------------------------------------------------------------
`default_nettype none
module v4n_sqrt_cell import v4n_pkg::*; #(
  parameter int SUM_W = 34,
  parameter int MAG_W = 16,
  parameter int BIT_POS = 0
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             vld_in,
  input  wire logic [SUM_W-1:0] rem_in,
  input  wire logic [SUM_W-1:0] res_in,
  input  wire logic [4*MAG_W-1:0] mag_in,
  input  wire logic [3:0]       neg_in,
  output logic                  vld_out,
  output logic [SUM_W-1:0]      rem_out,
  output logic [SUM_W-1:0]      res_out,
  output logic [4*MAG_W-1:0]    mag_out,
  output logic [3:0]            neg_out
);
  localparam logic [SUM_W-1:0] BITV = SUM_W'(1) << (2*BIT_POS);
  logic [SUM_W-1:0] trial;
  assign trial = res_in + BITV;

  always_ff @(posedge clk) begin
    if (rst) vld_out <= 1'b0;
    else vld_out <= vld_in;
    mag_out <= mag_in;
    neg_out <= neg_in;
    if (rem_in >= trial) begin
      rem_out <= rem_in - trial;
      res_out <= (res_in >> 1) + BITV;
    end else begin
      rem_out <= rem_in;
      res_out <= res_in >> 1;
    end
  end
endmodule
`default_nettype wire

@@ sv/v4n_div_cell.sv @@
// ---------------------------------------------------------------------------
// v4n_div_cell: one restoring-division stage for the four quotients
// Shifts in one dividend bit per lane and produces one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none
module v4n_div_cell import v4n_pkg::*; #(
  parameter int DVD_W = 30,
  parameter int DEN_W = 17
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 vld_in,
  input  wire logic [DEN_W-1:0]     den_in,
  input  wire logic [4*DVD_W-1:0]   dvd_in,
  input  wire logic [4*DEN_W-1:0]   rem_in,
  input  wire logic [4*DVD_W-1:0]   quo_in,
  input  wire logic [3:0]           neg_in,
  output logic                      vld_out,
  output logic [DEN_W-1:0]          den_out,
  output logic [4*DVD_W-1:0]        dvd_out,
  output logic [4*DEN_W-1:0]        rem_out,
  output logic [4*DVD_W-1:0]        quo_out,
  output logic [3:0]                neg_out
);
  always_ff @(posedge clk) begin
    if (rst) vld_out <= 1'b0;
    else vld_out <= vld_in;
    den_out <= den_in;
    neg_out <= neg_in;
    for (int i = 0; i < 4; i++) begin
      logic [DEN_W:0] sh;
      sh = {rem_in[i*DEN_W +: DEN_W], dvd_in[i*DVD_W + DVD_W-1]};
      dvd_out[i*DVD_W +: DVD_W] <= dvd_in[i*DVD_W +: DVD_W] << 1;
      if (sh >= {1'b0, den_in}) begin
        rem_out[i*DEN_W +: DEN_W] <= DEN_W'(sh - {1'b0, den_in});
        quo_out[i*DVD_W +: DVD_W] <= {quo_in[i*DVD_W +: DVD_W-1], 1'b1};
      end else begin
        rem_out[i*DEN_W +: DEN_W] <= sh[DEN_W-1:0];
        quo_out[i*DVD_W +: DVD_W] <= {quo_in[i*DVD_W +: DVD_W-1], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

@@ sv/vec4_normalize_unit.sv @@
// ---------------------------------------------------------------------------
// vec4_normalize_unit: four-component fixed-point vector normalizer
// Sum of squares, floor square root and four divisions in a chain of cells.
// ---------------------------------------------------------------------------
// An item is accepted on any rising edge with start high; busy is tied low,
// since a new item may enter every cycle. Stage 0 squares the four component
// magnitudes and stage 1 adds them. A chain of square-root cells follows,
// one cell per result bit (COMP_WIDTH+1 cells), each resolving one bit per
// cycle. A chain of division cells then forms all four quotients together,
// one quotient bit per cell (COMP_WIDTH+14 cells). The last stage applies
// signs and the zero-vector rule and drives the result with done high for
// one cycle. The unit takes one item per cycle. The receiver cannot stall,
// so nothing ever backs up. Reset clears only the valid bits in the chain;
// items in flight are dropped. For COMP_WIDTH above 16 the unit and length
// fields are truncated to their widths.
// ---------------------------------------------------------------------------
`default_nettype none
module vec4_normalize_unit import v4n_pkg::*; #(
  parameter int COMP_WIDTH = DEF_COMP_WIDTH
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  output logic          busy,
  input  wire vec_in_t  vec_in,
  output logic          done,
  output vec_out_t      vec_out
);
  localparam int MAG_W = COMP_WIDTH;
  localparam int SUM_W = 2*COMP_WIDTH + 2;
  localparam int NSQ = COMP_WIDTH + 1;
  localparam int DEN_W = COMP_WIDTH + 1;
  localparam int DVD_W = COMP_WIDTH + Q_SHIFT;

  assign busy = 1'b0;

  // Stage 0: magnitudes, signs and squares.
  logic [COMP_WIDTH-1:0] raw [4];
  logic [MAG_W-1:0] mg [4];
  logic [2*MAG_W-1:0] prod [4];
  logic [3:0] ng;
  assign raw[0] = COMP_WIDTH'(vec_in.comp_x);
  assign raw[1] = COMP_WIDTH'(vec_in.comp_y);
  assign raw[2] = COMP_WIDTH'(vec_in.comp_z);
  assign raw[3] = COMP_WIDTH'(vec_in.comp_w);
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ng[i] = raw[i][COMP_WIDTH-1];
      mg[i] = ng[i] ? (~raw[i] + 1'b1) : raw[i];
      prod[i] = mg[i] * mg[i];
    end
  end

  logic s0_vld;
  logic [SUM_W-1:0] sq [4];
  logic [4*MAG_W-1:0] s0_mag;
  logic [3:0] s0_neg;
  always_ff @(posedge clk) begin
    if (rst) s0_vld <= 1'b0;
    else s0_vld <= start;
    for (int i = 0; i < 4; i++) begin
      sq[i] <= SUM_W'(prod[i]);
      s0_mag[i*MAG_W +: MAG_W] <= mg[i];
    end
    s0_neg <= ng;
  end

  // Stage 1: sum of squares, exact in SUM_W bits.
  logic s1_vld;
  logic [SUM_W-1:0] s1_sum;
  logic [4*MAG_W-1:0] s1_mag;
  logic [3:0] s1_neg;
  always_ff @(posedge clk) begin
    if (rst) s1_vld <= 1'b0;
    else s1_vld <= s0_vld;
    s1_sum <= sq[0] + sq[1] + sq[2] + sq[3];
    s1_mag <= s0_mag;
    s1_neg <= s0_neg;
  end

  // Square-root chain, most significant bit first.
  logic sv [NSQ+1];
  logic [SUM_W-1:0] srem [NSQ+1];
  logic [SUM_W-1:0] sres [NSQ+1];
  logic [4*MAG_W-1:0] smag [NSQ+1];
  logic [3:0] sneg [NSQ+1];
  assign sv[0] = s1_vld;
  assign srem[0] = s1_sum;
  assign sres[0] = '0;
  assign smag[0] = s1_mag;
  assign sneg[0] = s1_neg;
  for (genvar k = 0; k < NSQ; k++) begin : g_sq
    v4n_sqrt_cell #(.SUM_W(SUM_W), .MAG_W(MAG_W), .BIT_POS(NSQ-1-k)) u_cell (
      .clk, .rst,
      .vld_in(sv[k]), .rem_in(srem[k]), .res_in(sres[k]),
      .mag_in(smag[k]), .neg_in(sneg[k]),
      .vld_out(sv[k+1]), .rem_out(srem[k+1]), .res_out(sres[k+1]),
      .mag_out(smag[k+1]), .neg_out(sneg[k+1])
    );
  end

  // Division chain; a zero length gives all-ones quotients, masked later.
  logic dv [DVD_W+1];
  logic [DEN_W-1:0] dden [DVD_W+1];
  logic [4*DVD_W-1:0] ddvd [DVD_W+1];
  logic [4*DEN_W-1:0] drem [DVD_W+1];
  logic [4*DVD_W-1:0] dquo [DVD_W+1];
  logic [3:0] dneg [DVD_W+1];
  assign dv[0] = sv[NSQ];
  assign dden[0] = DEN_W'(sres[NSQ]);
  always_comb begin
    for (int i = 0; i < 4; i++)
      ddvd[0][i*DVD_W +: DVD_W] = {smag[NSQ][i*MAG_W +: MAG_W], {Q_SHIFT{1'b0}}};
  end
  assign drem[0] = '0;
  assign dquo[0] = '0;
  assign dneg[0] = sneg[NSQ];
  for (genvar k = 0; k < DVD_W; k++) begin : g_div
    v4n_div_cell #(.DVD_W(DVD_W), .DEN_W(DEN_W)) u_cell (
      .clk, .rst,
      .vld_in(dv[k]), .den_in(dden[k]), .dvd_in(ddvd[k]), .rem_in(drem[k]),
      .quo_in(dquo[k]), .neg_in(dneg[k]),
      .vld_out(dv[k+1]), .den_out(dden[k+1]), .dvd_out(ddvd[k+1]),
      .rem_out(drem[k+1]), .quo_out(dquo[k+1]), .neg_out(dneg[k+1])
    );
  end

  // Output stage: signs, zero-vector rule, field truncation.
  logic zero;
  logic [UNIT_W-1:0] u [4];
  assign zero = (dden[DVD_W] == '0);
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      logic [UNIT_W-1:0] q;
      q = UNIT_W'(dquo[DVD_W][i*DVD_W +: DVD_W]);
      u[i] = zero ? '0 : (dneg[DVD_W][i] ? (~q + 1'b1) : q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= dv[DVD_W];
    vec_out.unit_x <= u[0];
    vec_out.unit_y <= u[1];
    vec_out.unit_z <= u[2];
    vec_out.unit_w <= u[3];
    vec_out.length <= LEN_W'(dden[DVD_W]);
    vec_out.zero_error <= zero;
  end
endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the four-component vector normalizer
// Drives directed and random vectors, predicts length and unit components
// from the fixed-point definition, and compares every strobed result in order.
// ---------------------------------------------------------------------------
`default_nettype none
module tb_top;
  import v4n_pkg::*;

  localparam int LATENCY = 49;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  vec_in_t  vec_in;
  logic     done;
  vec_out_t vec_out;

  vec_in_t  pending_vecs[$];
  vec_out_t expected_units[$];
  int       gap_draws[$];
  int       failures;
  bit       stim_done;

  vec4_normalize_unit u_top (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .vec_in  (vec_in),
    .done    (done),
    .vec_out (vec_out)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Floor square root by the classic digit-by-digit method.
  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Expected result for one vector: magnitude, then each component over it,
  // truncated toward zero in Q1.14. The all-zero vector raises the error flag.
  function automatic vec_out_t normalize(vec_in_t v);
    longint signed   comps[4];
    longint unsigned mags[4];
    longint unsigned sum;
    longint unsigned len;
    longint unsigned q;
    logic [UNIT_W-1:0] units[4];
    vec_out_t r;
    comps[0] = v.comp_x;
    comps[1] = v.comp_y;
    comps[2] = v.comp_z;
    comps[3] = v.comp_w;
    sum = 0;
    for (int i = 0; i < 4; i++) begin
      mags[i] = (comps[i] < 0) ? -comps[i] : comps[i];
      sum += mags[i] * mags[i];
    end
    len = isqrt(sum);
    r = '0;
    if (len == 0) begin
      r.zero_error = 1'b1;
      return r;
    end
    for (int i = 0; i < 4; i++) begin
      q = (mags[i] << Q_SHIFT) / len;
      if (comps[i] < 0) q = -q;
      units[i] = q[UNIT_W-1:0];
    end
    r.unit_x = units[0];
    r.unit_y = units[1];
    r.unit_z = units[2];
    r.unit_w = units[3];
    r.length = len[LEN_W-1:0];
    return r;
  endfunction

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 16'($signed($urandom_range(0, 16)) - 8);
      1: return 16'($urandom_range(0, 1) ? 16'h8000 : 16'h7fff);
      2: return 16'($signed($urandom_range(0, 1024)) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_vec(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                         logic [15:0] w);
    vec_in_t v;
    v.comp_x = x;
    v.comp_y = y;
    v.comp_z = z;
    v.comp_w = w;
    pending_vecs.push_back(v);
    gap_draws.push_back($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17));
  endtask

  // Stimulus: extremes, the zero vector, single-axis and mixed-sign cases, then
  // random vectors. Pauses after the directed set and mid-run let the pipe drain.
  initial begin
    failures = 0;
    stim_done = 1'b0;
    add_vec(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    add_vec(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    add_vec(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    add_vec(16'h8000, 16'h0000, 16'h0000, 16'h0000);
    add_vec(16'h0000, 16'h7fff, 16'h0000, 16'h0000);
    add_vec(16'h0000, 16'h0000, 16'h0001, 16'h0000);
    add_vec(16'h0000, 16'h0000, 16'h0000, 16'hffff);
    add_vec(16'h0001, 16'hffff, 16'h0001, 16'hffff);
    add_vec(16'h0100, 16'h0000, 16'h0000, 16'h0000);
    add_vec(16'hff00, 16'h0100, 16'hff00, 16'h0100);
    add_vec(16'h7fff, 16'h8000, 16'h0001, 16'hffff);
    add_vec(16'h0003, 16'h0004, 16'h0000, 16'h0000);
    add_vec(16'h5555, 16'haaaa, 16'h5555, 16'haaaa);
    add_vec(16'h0000, 16'h0000, 16'h0000, 16'h8000);
    // Marker: a negative gap asks the driver to wait for the pipe to drain.
    add_vec(16'h1234, 16'hedcc, 16'h0040, 16'hffc0);
    gap_draws[gap_draws.size()-1] = -1;
    for (int n = 0; n < 1800; n++) begin
      add_vec(rand_comp(), rand_comp(), rand_comp(), rand_comp());
      if (n == 900) gap_draws[gap_draws.size()-1] = -1;
    end
    stim_done = 1'b1;
  end

  // Driver: changes inputs on the falling edge. Start stays high through
  // back-to-back items and drops only when a gap is drawn or no item is left.
  int  wait_left;
  bit  hold_off;
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
      vec_in <= '0;
      wait_left = 0;
      hold_off = 1'b0;
    end else if (start && busy) begin
      // Item not yet taken; keep it on the bus.
    end else if (hold_off) begin
      start <= 1'b0;
      if (expected_units.size() == 0) hold_off = 1'b0;
    end else if (wait_left > 0) begin
      start <= 1'b0;
      wait_left--;
    end else if (pending_vecs.size() != 0) begin
      int g;
      g = gap_draws.pop_front();
      if (g < 0) begin
        hold_off = 1'b1;
        g = 0;
      end
      if (g == 0 || start) begin
        vec_in <= pending_vecs.pop_front();
        start <= 1'b1;
        wait_left = g;
      end else begin
        gap_draws.push_front(0);
        wait_left = g - 1;
        start <= 1'b0;
      end
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: on each rising edge, an accepted item feeds the predictor and
  // a strobed result is checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        if (expected_units.size() == 0) begin
          $display("%0t: unexpected result %h", $time, vec_out);
          failures++;
        end else begin
          vec_out_t e;
          e = expected_units.pop_front();
          if (e.unit_x !== vec_out.unit_x)
            $display("%0t: unit_x expected %0d actual %0d", $time, e.unit_x, vec_out.unit_x);
          if (e.unit_y !== vec_out.unit_y)
            $display("%0t: unit_y expected %0d actual %0d", $time, e.unit_y, vec_out.unit_y);
          if (e.unit_z !== vec_out.unit_z)
            $display("%0t: unit_z expected %0d actual %0d", $time, e.unit_z, vec_out.unit_z);
          if (e.unit_w !== vec_out.unit_w)
            $display("%0t: unit_w expected %0d actual %0d", $time, e.unit_w, vec_out.unit_w);
          if (e.length !== vec_out.length)
            $display("%0t: length expected %0d actual %0d", $time, e.length, vec_out.length);
          if (e.zero_error !== vec_out.zero_error)
            $display("%0t: zero_error expected %b actual %b", $time, e.zero_error,
                     vec_out.zero_error);
          if (e !== vec_out) failures++;
        end
      end
      if (start && !busy) expected_units.push_back(normalize(vec_in));
    end
  end

  initial begin
    rst = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    wait (stim_done && pending_vecs.size() == 0 && !start);
    wait (expected_units.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #400000;
    $display("FAIL");
    $finish;
  end
endmodule
`default_nettype wire
